/* rtl/ppp_pkg.sv */
`default_nettype none
package ppp_pkg;

    localparam int COEF_W     = 32;
    localparam int POS_W      = 32;
    localparam int IDX_W      = 4;
    localparam int NUM_COEF   = 16;
    localparam int SIZE_W     = 14;
    localparam int HALF_W     = SIZE_W - 1;
    localparam int DEPTH_W    = 31;
    localparam int SCREEN_W   = 16;
    localparam int QUO_BITS   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int PROD_W     = COEF_W + POS_W;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 32;

    // Command codes carried on the input tuser.
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH     = 2'd3;

    localparam logic [SIZE_W-1:0]  RST_WINDOW_WIDTH  = 14'd1920;
    localparam logic [SIZE_W-1:0]  RST_WINDOW_HEIGHT = 14'd1080;
    localparam logic [DEPTH_W-1:0] RST_MIN_DEPTH     = 31'd30720;

    localparam logic [SCREEN_W-1:0] PIX_MAX = 16'h7FFF;
    localparam logic [SCREEN_W-1:0] PIX_MIN = 16'h8000;

    // Per-point flags that ride alongside the divider.
    typedef struct packed {
        logic visible;
        logic neg_x;
        logic neg_y;
    } ppp_side_t;

    // Signs and saturates a truncated quotient magnitude to a pixel value.
    function automatic logic [SCREEN_W-1:0] sat_pixel(input logic neg, input logic ovf,
                                                      input logic [QUO_BITS-1:0] q);
        logic [SCREEN_W-1:0] res;
        if (!neg)
        begin
            res = (ovf || q >= PIX_MAX) ? PIX_MAX : q;
        end
        else
        begin
            res = (ovf || q >= PIX_MIN) ? PIX_MIN : (~q + 16'd1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/perspective_point_projection_core.sv */
// Most of the pipeline is the 17 stages of the restoring divider: an overflow
// check, then one quotient bit per stage.
// Throughput: one word per cycle, loads and projections alike; every stage is
// pipelined and the whole pipeline stalls only while a result word waits.
// Reset (rst_n, asynchronous, active low) empties the pipeline and restores the
// configuration defaults; the matrix store is undefined until loaded.
`default_nettype none
module perspective_point_projection_core #(
    parameter int COEF_FRAC_BITS = 16,
    parameter int POS_FRAC_BITS  = 8
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Input stream.
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // tdata: coef_index[3:0], coef_value[35:4], pos_x[67:36], pos_y[99:68],
    // pos_z[131:100], zero padding above.
    input  wire [ppp_pkg::IN_TDATA_W-1:0]       s_tdata,
    // tuser: cmd.
    input  wire                                 s_tuser,
    // Output stream.
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // tdata: screen_x[15:0], screen_y[31:16].
    output logic [ppp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // tuser: visible.
    output logic                                m_tuser,
    // Configuration write port.
    input  wire                                 cfg_we,
    input  wire [ppp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [ppp_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ppp_pkg::*;

    // Each product term is floored to the point format, leaving
    // PROD_W - COEF_FRAC_BITS bits; four of them sum with two bits of growth.
    localparam int CLIP_W = PROD_W - COEF_FRAC_BITS + 2;
    localparam int A_W    = CLIP_W + 1;
    localparam int N_W    = A_W + HALF_W;

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic               flip_reg;
    logic [DEPTH_W-1:0] depth_reg;

    logic               adv;

    logic               clip_valid;
    logic signed [CLIP_W-1:0] clip_x;
    logic signed [CLIP_W-1:0] clip_y;
    logic signed [CLIP_W-1:0] clip_w;

    logic               d_valid_reg;
    logic signed [A_W-1:0] d_ax_reg;
    logic signed [A_W-1:0] d_ay_reg;
    logic signed [CLIP_W-1:0] d_w_reg;
    logic               d_vis_reg;

    logic               e_valid_reg;
    logic [A_W-1:0]     e_mx_reg;
    logic [A_W-1:0]     e_my_reg;
    logic [CLIP_W-1:0]  e_w_reg;
    ppp_side_t          e_side_reg;

    logic [N_W-1:0]     num_x;
    logic [N_W-1:0]     num_y;

    logic               div_valid;
    ppp_side_t          div_side;
    logic               ovf_x;
    logic               ovf_y;
    logic [QUO_BITS-1:0] quo_x;
    logic [QUO_BITS-1:0] quo_y;

    logic               out_valid_reg;
    logic               out_vis_reg;
    logic [SCREEN_W-1:0] out_x_reg;
    logic [SCREEN_W-1:0] out_y_reg;
    logic [SCREEN_W-1:0] out_x_next;
    logic [SCREEN_W-1:0] out_y_next;

    // The whole pipeline moves together whenever the output register is free
    // or being drained, so a new word is taken in every such cycle.
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WINDOW_WIDTH;
            height_reg <= RST_WINDOW_HEIGHT;
            flip_reg   <= 1'b0;
            depth_reg  <= RST_MIN_DEPTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                REG_WINDOW_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                REG_FLIP_Y:        flip_reg   <= cfg_data[0];
                REG_MIN_DEPTH:     depth_reg  <= cfg_data[DEPTH_W-1:0];
                default:           ;
            endcase
        end
    end

    // Matrix store, the nine coefficient products and the row sums.
    ppp_clip #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .POS_FRAC_BITS  (POS_FRAC_BITS),
        .CLIP_W         (CLIP_W)
    ) u_clip (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (s_tvalid),
        .cmd        (s_tuser),
        .coef_index (s_tdata[3:0]),
        .coef_value (s_tdata[35:4]),
        .pos_x      (s_tdata[67:36]),
        .pos_y      (s_tdata[99:68]),
        .pos_z      (s_tdata[131:100]),
        .out_valid  (clip_valid),
        .clip_x     (clip_x),
        .clip_y     (clip_y),
        .clip_w     (clip_w)
    );

    // Numerators of the screen mapping: c + w, or w - c for a flipped y.
    // A point is visible when w reaches the threshold and is not zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= clip_valid;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_ax_reg  <= A_W'(clip_x) + A_W'(clip_w);
            d_ay_reg  <= flip_reg ? (A_W'(clip_w) - A_W'(clip_y))
                                  : (A_W'(clip_y) + A_W'(clip_w));
            d_w_reg   <= clip_w;
            d_vis_reg <= (clip_w >= $signed({{(CLIP_W-DEPTH_W){1'b0}}, depth_reg}))
                         && (clip_w != '0);
        end
    end

    // Magnitudes and signs; the divider works on unsigned values.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_mx_reg           <= d_ax_reg[A_W-1] ? A_W'(-d_ax_reg) : A_W'(d_ax_reg);
            e_my_reg           <= d_ay_reg[A_W-1] ? A_W'(-d_ay_reg) : A_W'(d_ay_reg);
            e_w_reg            <= d_w_reg;
            e_side_reg.visible <= d_vis_reg;
            e_side_reg.neg_x   <= d_ax_reg[A_W-1];
            e_side_reg.neg_y   <= d_ay_reg[A_W-1];
        end
    end

    // Half size times the numerator magnitude, registered at the divider input.
    assign num_x = {{(N_W-HALF_W){1'b0}}, width_reg[SIZE_W-1:1]}
                 * {{HALF_W{1'b0}}, e_mx_reg};
    assign num_y = {{(N_W-HALF_W){1'b0}}, height_reg[SIZE_W-1:1]}
                 * {{HALF_W{1'b0}}, e_my_reg};

    ppp_div #(
        .N_W (N_W),
        .D_W (CLIP_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (e_valid_reg),
        .side_in   (e_side_reg),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (e_w_reg),
        .out_valid (div_valid),
        .side_out  (div_side),
        .ovf_x     (ovf_x),
        .quo_x     (quo_x),
        .ovf_y     (ovf_y),
        .quo_y     (quo_y)
    );

    // Truncated quotients are signed, saturated and forced to zero for a
    // point that is not visible.
    always_comb
    begin
        out_x_next = '0;
        out_y_next = '0;
        if (div_side.visible)
        begin
            out_x_next = sat_pixel(div_side.neg_x, ovf_x, quo_x);
            out_y_next = sat_pixel(div_side.neg_y, ovf_y, quo_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_vis_reg <= div_side.visible;
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_vis_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};

endmodule
`default_nettype wire

/* rtl/ppp_clip.sv */
`default_nettype none
module ppp_clip #(
    parameter int COEF_FRAC_BITS = 16,
    parameter int POS_FRAC_BITS  = 8,
    parameter int CLIP_W         = 66 - COEF_FRAC_BITS
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire                          cmd,
    input  wire [ppp_pkg::IDX_W-1:0]     coef_index,
    input  wire [ppp_pkg::COEF_W-1:0]    coef_value,
    input  wire [ppp_pkg::POS_W-1:0]     pos_x,
    input  wire [ppp_pkg::POS_W-1:0]     pos_y,
    input  wire [ppp_pkg::POS_W-1:0]     pos_z,
    output logic                         out_valid,
    output logic signed [CLIP_W-1:0]     clip_x,
    output logic signed [CLIP_W-1:0]     clip_y,
    output logic signed [CLIP_W-1:0]     clip_w
);
    import ppp_pkg::*;

    localparam int TERM_W = PROD_W - COEF_FRAC_BITS;

    logic [COEF_W-1:0] coef_reg [0:NUM_COEF-1];

    logic              a_valid_reg;
    logic [POS_W-1:0]  pos_reg [0:2];
    logic              b_valid_reg;
    logic signed [PROD_W-1:0] prod_reg [0:2][0:2];
    logic [COEF_W-1:0] trans_reg [0:2];
    logic              c_valid_reg;
    logic signed [CLIP_W-1:0] clip_reg [0:2];

    // Matrix store: written by load words as they are accepted.
    always_ff @(posedge clk)
    begin
        if (en && in_valid && cmd == CMD_LOAD)
        begin
            coef_reg[coef_index] <= coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid && cmd == CMD_PROJECT;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
        end
    end

    // Lanes 0, 1 and 2 evaluate matrix rows 0, 1 and 3.
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        localparam int ROW = (l == 2) ? 3 : l;

        logic signed [PROD_W-1:0] shifted [0:3];
        logic signed [PROD_W-1:0] trans_wide;
        logic signed [CLIP_W-1:0] sum_next;

        for (genvar k = 0; k < 3; k++)
        begin : g_mul
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[l][k] <= $signed(coef_reg[ROW*4+k]) * $signed(pos_reg[k]);
                end
            end
            assign shifted[k] = prod_reg[l][k] >>> COEF_FRAC_BITS;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                trans_reg[l] <= coef_reg[ROW*4+3];
            end
        end

        assign trans_wide = {{(PROD_W-COEF_W){trans_reg[l][COEF_W-1]}}, trans_reg[l]}
                            <<< POS_FRAC_BITS;
        assign shifted[3] = trans_wide >>> COEF_FRAC_BITS;

        always_comb
        begin
            sum_next = (CLIP_W)'($signed(shifted[0][TERM_W-1:0]))
                     + (CLIP_W)'($signed(shifted[1][TERM_W-1:0]))
                     + (CLIP_W)'($signed(shifted[2][TERM_W-1:0]))
                     + (CLIP_W)'($signed(shifted[3][TERM_W-1:0]));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                clip_reg[l] <= sum_next;
            end
        end
    end

    assign out_valid = c_valid_reg;
    assign clip_x    = clip_reg[0];
    assign clip_y    = clip_reg[1];
    assign clip_w    = clip_reg[2];

endmodule
`default_nettype wire

/* rtl/ppp_div.sv */
`default_nettype none
module ppp_div #(
    parameter int N_W = 72,
    parameter int D_W = 58
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              en,
    input  wire                              in_valid,
    input  ppp_pkg::ppp_side_t               side_in,
    input  wire [N_W-1:0]                    num_x,
    input  wire [N_W-1:0]                    num_y,
    input  wire [D_W-1:0]                    den,
    output logic                             out_valid,
    output ppp_pkg::ppp_side_t               side_out,
    output logic                             ovf_x,
    output logic [ppp_pkg::QUO_BITS-1:0]     quo_x,
    output logic                             ovf_y,
    output logic [ppp_pkg::QUO_BITS-1:0]     quo_y
);
    import ppp_pkg::*;

    localparam int STEPS = QUO_BITS + 1;
    localparam int DIV_W = ((N_W > D_W + QUO_BITS) ? N_W : D_W + QUO_BITS) + 1;

    logic                 valid_reg [0:STEPS];
    ppp_side_t            side_reg  [0:STEPS];
    logic [D_W-1:0]       den_reg   [0:STEPS];
    logic [N_W-1:0]       rem_reg   [0:1][0:STEPS];
    logic [QUO_BITS-1:0]  q_reg     [0:1][0:STEPS];
    logic                 ovf_reg   [0:1][0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0]   <= side_in;
            den_reg[0]    <= den;
            rem_reg[0][0] <= num_x;
            rem_reg[1][0] <= num_y;
            q_reg[0][0]   <= '0;
            q_reg[1][0]   <= '0;
            ovf_reg[0][0] <= 1'b0;
            ovf_reg[1][0] <= 1'b0;
        end
    end

    // Step 0 checks for a quotient of 2^QUO_BITS or more; each later step
    // resolves one quotient bit, most significant first.
    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        localparam int SH = (s == 0) ? QUO_BITS : QUO_BITS - s;

        logic [DIV_W-1:0] trial;

        assign trial = {{(DIV_W-D_W){1'b0}}, den_reg[s]} << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s+1] <= side_reg[s];
                den_reg[s+1]  <= den_reg[s];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [DIV_W-1:0] rem_wide;
            logic [DIV_W-1:0] diff;
            logic             ge;

            assign rem_wide = {{(DIV_W-N_W){1'b0}}, rem_reg[l][s]};
            assign ge       = rem_wide >= trial;
            assign diff     = rem_wide - trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (s == 0)
                    begin
                        rem_reg[l][s+1] <= rem_reg[l][s];
                        q_reg[l][s+1]   <= q_reg[l][s];
                        ovf_reg[l][s+1] <= ge;
                    end
                    else
                    begin
                        rem_reg[l][s+1] <= ge ? diff[N_W-1:0] : rem_reg[l][s];
                        q_reg[l][s+1]   <= q_reg[l][s] | (QUO_BITS'(ge) << SH);
                        ovf_reg[l][s+1] <= ovf_reg[l][s];
                    end
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign side_out  = side_reg[STEPS];
    assign ovf_x     = ovf_reg[0][STEPS];
    assign quo_x     = q_reg[0][STEPS];
    assign ovf_y     = ovf_reg[1][STEPS];
    assign quo_y     = q_reg[1][STEPS];

endmodule
`default_nettype wire

/* rtl/ppp_checker.sv */
`default_nettype none
module ppp_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_tready,
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire [ppp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  wire                             m_tuser
);

    // A result word held back by the sink stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // The input side is ready exactly when the output register can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output register state");

    // A point that is not visible reports zero coordinates.
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("hidden point with nonzero coordinates");

    // Reset leaves no result word on the output.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result word present out of reset");

endmodule

bind perspective_point_projection_core ppp_checker u_ppp_checker (.*);
`default_nettype wire
